@@ rtl/fvpc_pkg.sv @@
// Shared constants for the FOC voltage-to-PWM compare pipeline.
// Field widths, parameter defaults and the stage latencies of each unit.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package fvpc_pkg;

	// Parameter defaults for the top level.
	localparam int SINE_DEPTH_DEF = 256;
	localparam int VOLT_BITS_DEF  = 16;

	// Fixed field widths.
	localparam int ANGLE_W   = 16;
	localparam int PERIOD_W  = 16;
	localparam int COMPARE_W = 16;

	// Quotient bits resolved by the divider lanes (one per stage).
	localparam int QUO_BITS = 16;

	// Duty in Q.17: 0..131072, so two bits above the quotient.
	localparam int DUTY2_W = QUO_BITS + 2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4000;

	// Register stages per unit.
	localparam int SINE_LAT = 3;
	localparam int PC_LAT   = 2;
	localparam int DIV_LAT  = QUO_BITS + 2;
	localparam int MID_LAT  = 3;
	localparam int PIPE_LAT = SINE_LAT + PC_LAT + DIV_LAT + MID_LAT;

endpackage

@@ rtl/foc_voltage_to_pwm_compare.sv @@
// Top level of the FOC voltage-to-PWM compare pipeline.
// Instantiates fvpc_sine, fvpc_park_clarke, fvpc_div and fvpc_midclamp;
// constants come from fvpc_pkg.
//
// One transaction on the slave stream carries a d/q voltage command, the
// electrical angle, three phase offsets and the DC bus voltage. For each one
// the master stream delivers one transaction with the three timer compare
// values for phases A, B and C, in the order the commands arrived.
// The configuration port writes the PWM period (reset value 4000) whenever
// cfg_we is high; it should only be written while no transaction is in flight.
// There are 26 register stages: three for the sine lookup, two for the Park and
// Clarke transforms, eighteen for the divider lanes (one quotient bit per
// stage) and three for the midpoint clamp and period scaling. It takes one
// transaction per cycle unless the output stage stalls. The whole pipeline
// advances together: while a result waits in the output stage with m_tready
// low every stage holds, bubbles included, so s_tready follows m_tready
// whenever the output stage is occupied.
// Reset clears all valid bits, so nothing is presented until a new
// transaction has passed through; the period returns to its reset value.
module foc_voltage_to_pwm_compare #(
	parameter int SINE_TABLE_DEPTH = fvpc_pkg::SINE_DEPTH_DEF,
	parameter int VOLT_BITS        = fvpc_pkg::VOLT_BITS_DEF,
	localparam int IN_W  = ((6 * VOLT_BITS + 15 + 7) / 8) * 8,
	localparam int OUT_W = 3 * fvpc_pkg::COMPARE_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fvpc_pkg::PERIOD_W-1:0] cfg_wdata,   // pwm_period
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// volt_q, volt_d, elec_angle, offset_a, offset_b, offset_c, supply_voltage
	input  logic [IN_W-1:0]               s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// compare_a, compare_b, compare_c
	output logic [OUT_W-1:0]              m_tdata
);

	localparam int VB      = VOLT_BITS;
	localparam int UW      = VB + 18;
	localparam int SIDE_W  = 6 * VB - 1;
	localparam int OFS_D   = VB;
	localparam int OFS_ANG = 2 * VB;
	localparam int OFS_OFF = 2 * VB + fvpc_pkg::ANGLE_W;
	localparam int OFS_VS  = 5 * VB + fvpc_pkg::ANGLE_W;
	localparam int LAT     = fvpc_pkg::PIPE_LAT;

	// Configuration register.
	logic [fvpc_pkg::PERIOD_W-1:0] pwm_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= fvpc_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			pwm_period_q <= cfg_wdata;
		end
	end

	// Pipeline control: one valid bit per stage, all stages share one enable.
	logic           en;
	logic [LAT-1:0] valid_q;

	assign en       = !valid_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = valid_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LAT-2:0], s_tvalid};
		end
	end

	// A zero bus voltage is treated as one LSB so the divider never sees zero.
	logic [VB-2:0]     supply_in;
	logic [VB-2:0]     supply_fix;
	logic [SIDE_W-1:0] side_in;
	logic [SIDE_W-1:0] side_s1;
	logic [SIDE_W-1:0] side_s2;
	logic [SIDE_W-1:0] side_s3;

	assign supply_in  = s_tdata[OFS_VS +: (VB - 1)];
	assign supply_fix = (supply_in == '0) ? (VB - 1)'(1) : supply_in;
	assign side_in    = {supply_fix, s_tdata[OFS_OFF +: 3 * VB], s_tdata[0 +: 2 * VB]};

	// The command and offsets wait beside the sine lookup.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end

	logic signed [15:0] sin_val;
	logic signed [15:0] cos_val;

	fvpc_sine #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_sine (
		.clk    (clk),
		.en     (en),
		.angle  (s_tdata[OFS_ANG +: fvpc_pkg::ANGLE_W]),
		.sin_val(sin_val),
		.cos_val(cos_val)
	);

	logic signed [VB-1:0] offset_s3 [3];
	logic signed [UW-1:0] u_phase [3];
	logic [VB-2:0]        supply_pc;

	for (genvar j = 0; j < 3; j++) begin : g_offset
		assign offset_s3[j] = $signed(side_s3[(2 + j) * VB +: VB]);
	end

	fvpc_park_clarke #(
		.VOLT_BITS(VOLT_BITS)
	) u_park_clarke (
		.clk       (clk),
		.en        (en),
		.sin_val   (sin_val),
		.cos_val   (cos_val),
		.volt_q    ($signed(side_s3[0 +: VB])),
		.volt_d    ($signed(side_s3[OFS_D +: VB])),
		.offset    (offset_s3),
		.supply    (side_s3[5 * VB +: (VB - 1)]),
		.u_phase   (u_phase),
		.supply_out(supply_pc)
	);

	// One divider lane per phase, all fed with the same bus voltage.
	logic [fvpc_pkg::DUTY2_W-1:0] duty2 [3];

	for (genvar j = 0; j < 3; j++) begin : g_div
		fvpc_div #(
			.VOLT_BITS(VOLT_BITS)
		) u_div (
			.clk   (clk),
			.en    (en),
			.u     (u_phase[j]),
			.supply(supply_pc),
			.duty2 (duty2[j])
		);
	end

	logic [fvpc_pkg::COMPARE_W-1:0] compare [3];

	// The last stage of this unit is the output register of the block.
	fvpc_midclamp u_midclamp (
		.clk    (clk),
		.en     (en),
		.duty2  (duty2),
		.period (pwm_period_q),
		.compare(compare)
	);

	assign m_tdata = {compare[2], compare[1], compare[0]};

endmodule

@@ rtl/fvpc_sine.sv @@
// Sine and cosine of the electrical angle from a quarter-wave table with
// linear interpolation, three register stages. Uses fvpc_pkg.
// The table is built at elaboration from a fixed-point Taylor series.
module fvpc_sine #(
	parameter int SINE_TABLE_DEPTH = fvpc_pkg::SINE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [fvpc_pkg::ANGLE_W-1:0]      angle,
	output logic signed [15:0]                sin_val,
	output logic signed [15:0]                cos_val
);

	localparam int IDXW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW   = 15 + IDXW;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SINE_TABLE_DEPTH);
	localparam logic [fvpc_pkg::ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

	// Table entry k: Taylor sum of sin(pi/2 * k / depth) in Q30, scaled to Q1.15.
	function automatic logic [14:0] rom_entry(input int k);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        v;
		x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
		term = x;
		sum  = $signed(x);
		for (int n = 1; n <= 6; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			case (n)
				1:       term = term / 64'd6;
				2:       term = term / 64'd20;
				3:       term = term / 64'd42;
				4:       term = term / 64'd72;
				5:       term = term / 64'd110;
				default: term = term / 64'd156;
			endcase
			if (n[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[14:0];
	endfunction

	logic [14:0] rom [0:SINE_TABLE_DEPTH];

	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [14:0] ENTRY = rom_entry(k);
		assign rom[k] = ENTRY;
	end

	logic [fvpc_pkg::ANGLE_W-1:0] lane_angle [2];
	logic signed [15:0]           lane_out [2];

	assign lane_angle[0] = angle;
	assign lane_angle[1] = angle + QUARTER_TURN;

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [14:0]         pm;
		logic [PW-1:0]       prod;
		logic [IDXW-1:0]     idx_s1;
		logic [13:0]         frac_s1;
		logic                neg_s1;
		logic [IDXW-1:0]     idx_nx;
		logic [14:0]         a_s2;
		logic [14:0]         b_s2;
		logic [13:0]         frac_s2;
		logic                neg_s2;
		logic signed [16:0]  diff;
		logic signed [31:0]  interp;
		logic signed [16:0]  mag;
		logic signed [15:0]  val_s3;

		// Odd quadrants run the quarter wave backwards.
		assign pm = lane_angle[l][14] ? (15'd16384 - {1'b0, lane_angle[l][13:0]})
		                              : {1'b0, lane_angle[l][13:0]};
		assign prod = PW'(pm) * PW'(SINE_TABLE_DEPTH);

		always_ff @(posedge clk) begin
			if (en) begin
				idx_s1  <= prod[14 +: IDXW];
				frac_s1 <= prod[13:0];
				neg_s1  <= lane_angle[l][15];
			end
		end

		assign idx_nx = (idx_s1 == LAST_IDX) ? idx_s1 : idx_s1 + 1'b1;

		always_ff @(posedge clk) begin
			if (en) begin
				a_s2    <= rom[idx_s1];
				b_s2    <= rom[idx_nx];
				frac_s2 <= frac_s1;
				neg_s2  <= neg_s1;
			end
		end

		assign diff   = $signed({2'b00, b_s2}) - $signed({2'b00, a_s2});
		assign interp = 32'(diff) * 32'($signed({1'b0, frac_s2}));
		assign mag    = $signed({2'b00, a_s2}) + 17'(interp >>> 14);

		always_ff @(posedge clk) begin
			if (en) begin
				val_s3 <= neg_s2 ? 16'(-mag) : 16'(mag);
			end
		end

		assign lane_out[l] = val_s3;
	end

	assign sin_val = lane_out[0];
	assign cos_val = lane_out[1];

endmodule

@@ rtl/fvpc_park_clarke.sv @@
// Inverse Park and inverse Clarke transforms with offset subtraction,
// two register stages, phase voltages in signed Q.15. Uses fvpc_pkg.
module fvpc_park_clarke #(
	parameter int VOLT_BITS = fvpc_pkg::VOLT_BITS_DEF,
	localparam int UW = VOLT_BITS + 18
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [15:0]          sin_val,
	input  logic signed [15:0]          cos_val,
	input  logic signed [VOLT_BITS-1:0] volt_q,
	input  logic signed [VOLT_BITS-1:0] volt_d,
	input  logic signed [VOLT_BITS-1:0] offset [3],
	input  logic [VOLT_BITS-2:0]        supply,
	output logic signed [UW-1:0]        u_phase [3],
	output logic [VOLT_BITS-2:0]        supply_out
);

	localparam int AW = VOLT_BITS + 16;
	localparam int CW = VOLT_BITS + 34;
	localparam logic signed [17:0]   SQRT3_HALF_Q16 = 18'sd56756;
	localparam logic signed [CW-1:0] RND_HALF       = CW'(32768);

	logic signed [AW-1:0]        ualpha;
	logic signed [AW-1:0]        ubeta;
	logic signed [AW-1:0]        ualpha_s1;
	logic signed [AW-1:0]        ubeta_s1;
	logic signed [VOLT_BITS-1:0] offset_s1 [3];
	logic [VOLT_BITS-2:0]        supply_s1;

	assign ualpha = AW'(cos_val) * AW'(volt_d) - AW'(sin_val) * AW'(volt_q);
	assign ubeta  = AW'(sin_val) * AW'(volt_d) + AW'(cos_val) * AW'(volt_q);

	always_ff @(posedge clk) begin
		if (en) begin
			ualpha_s1 <= ualpha;
			ubeta_s1  <= ubeta;
			offset_s1 <= offset;
			supply_s1 <= supply;
		end
	end

	logic signed [CW-1:0] kbeta;
	logic signed [CW-1:0] alpha_half;
	logic signed [CW-1:0] rnd_b;
	logic signed [CW-1:0] rnd_c;
	logic signed [UW-1:0] ub;
	logic signed [UW-1:0] uc;
	logic signed [UW-1:0] off_sh [3];

	// Phases B and C: (-alpha/2 +/- sqrt3/2 * beta), rounded half up in Q16.
	assign kbeta      = CW'(ubeta_s1) * CW'(SQRT3_HALF_Q16);
	assign alpha_half = CW'(ualpha_s1) <<< 15;
	assign rnd_b      = (kbeta - alpha_half + RND_HALF) >>> 16;
	assign rnd_c      = (-kbeta - alpha_half + RND_HALF) >>> 16;
	assign ub         = $signed(rnd_b[UW-1:0]);
	assign uc         = $signed(rnd_c[UW-1:0]);

	for (genvar j = 0; j < 3; j++) begin : g_off
		assign off_sh[j] = UW'(offset_s1[j]) <<< 15;
	end

	logic signed [UW-1:0] u_s2 [3];
	logic [VOLT_BITS-2:0] supply_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s2[0]   <= UW'(ualpha_s1) - off_sh[0];
			u_s2[1]   <= ub - off_sh[1];
			u_s2[2]   <= uc - off_sh[2];
			supply_s2 <= supply_s1;
		end
	end

	assign u_phase    = u_s2;
	assign supply_out = supply_s2;

endmodule

@@ rtl/fvpc_div.sv @@
// One divider lane: duty = clamp(round(U / Vs) + 0.5, 0, 1) as Q.17,
// restoring division one quotient bit per stage. Uses fvpc_pkg.
module fvpc_div #(
	parameter int VOLT_BITS = fvpc_pkg::VOLT_BITS_DEF,
	localparam int UW = VOLT_BITS + 18
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [UW-1:0]             u,
	input  logic [VOLT_BITS-2:0]             supply,
	output logic [fvpc_pkg::DUTY2_W-1:0]     duty2
);

	localparam int QB = fvpc_pkg::QUO_BITS;
	localparam int MW = VOLT_BITS + 17;
	localparam int NW = VOLT_BITS + 19;
	localparam int DW = VOLT_BITS;
	localparam logic [QB-1:0] HALF_Q = QB'(1) << (QB - 1);

	logic [UW-1:0] mag_full;
	logic [MW-1:0] mag;
	logic [NW-1:0] num;
	logic [DW-1:0] den;

	// Rounded half away from zero: (2|U| + Vs) / (2 Vs), sign put back later.
	assign mag_full = u[UW-1] ? (~u + 1'b1) : u;
	assign mag      = mag_full[MW-1:0];
	assign num      = NW'({mag, 1'b0}) + NW'(supply);
	assign den      = {supply, 1'b0};

	logic [NW-1:0] rem_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic          neg_s [0:QB];
	logic          ovf_s [0:QB];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= u[UW-1];
			ovf_s[0] <= num >= NW'({den, {QB{1'b0}}});
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [NW-1:0] trial;
		logic          ge;

		assign trial = NW'(den_s[k-1]) << (QB - k);
		assign ge    = rem_s[k-1] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? rem_s[k-1] - trial : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | (QB'(ge) << (QB - k));
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	logic [QB-1:0] qsat;
	logic [QB:0]   duty;
	logic [fvpc_pkg::DUTY2_W-1:0] duty2_s;

	assign qsat = (ovf_s[QB] || (quo_s[QB] >= HALF_Q)) ? HALF_Q : quo_s[QB];
	assign duty = neg_s[QB] ? ({1'b0, HALF_Q} - {1'b0, qsat})
	                        : ({1'b0, HALF_Q} + {1'b0, qsat});

	always_ff @(posedge clk) begin
		if (en) begin
			duty2_s <= {duty, 1'b0};
		end
	end

	assign duty2 = duty2_s;

endmodule

@@ rtl/fvpc_midclamp.sv @@
// Midpoint-clamp zero-sequence shift, second clamp and scaling by the PWM
// period with rounding, three register stages. Uses fvpc_pkg.
module fvpc_midclamp (
	input  logic                              clk,
	input  logic                              en,
	input  logic [fvpc_pkg::DUTY2_W-1:0]      duty2 [3],
	input  logic [fvpc_pkg::PERIOD_W-1:0]     period,
	output logic [fvpc_pkg::COMPARE_W-1:0]    compare [3]
);

	localparam int DW  = fvpc_pkg::DUTY2_W;
	localparam int TW  = DW + 2;
	localparam int PRW = DW + fvpc_pkg::PERIOD_W + 1;
	localparam logic signed [TW-1:0] MID  = TW'(1) <<< (DW - 2);
	localparam logic signed [TW-1:0] FULL = TW'(1) <<< (DW - 1);
	localparam logic [PRW-1:0]       RND  = PRW'(1) << (DW - 2);

	logic [DW-1:0] hi;
	logic [DW-1:0] lo;
	logic [DW-1:0] duty_s1 [3];
	logic [DW:0]   hilo_s1;

	always_comb begin
		hi = duty2[0];
		lo = duty2[0];
		for (int j = 1; j < 3; j++) begin
			if (duty2[j] > hi) begin
				hi = duty2[j];
			end
			if (duty2[j] < lo) begin
				lo = duty2[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			duty_s1 <= duty2;
			hilo_s1 <= {1'b0, hi} + {1'b0, lo};
		end
	end

	logic [DW-1:0] dd_s2 [3];
	logic [fvpc_pkg::COMPARE_W-1:0] cmp_s3 [3];

	for (genvar j = 0; j < 3; j++) begin : g_phase
		logic signed [TW-1:0] shifted;
		logic [PRW-1:0]       prod;

		assign shifted = $signed({2'b00, duty_s1[j]}) + MID - $signed({1'b0, hilo_s1});

		always_ff @(posedge clk) begin
			if (en) begin
				if (shifted < 0) begin
					dd_s2[j] <= '0;
				end else if (shifted > FULL) begin
					dd_s2[j] <= FULL[DW-1:0];
				end else begin
					dd_s2[j] <= shifted[DW-1:0];
				end
			end
		end

		assign prod = PRW'(dd_s2[j]) * PRW'(period) + RND;

		always_ff @(posedge clk) begin
			if (en) begin
				cmp_s3[j] <= prod[(DW - 1) +: fvpc_pkg::COMPARE_W];
			end
		end
	end

	assign compare = cmp_s3;

endmodule

@@ verif/fvpc_compare_checker.sv @@
// Result checker for the FOC voltage-to-PWM compare pipeline.
// Predicts the three compare values for every accepted command and compares them with the
// results in order. Depends on fvpc_pkg for widths and the period reset value.
module fvpc_compare_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fvpc_pkg::PERIOD_W-1:0] cfg_wdata,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [111:0]                  s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [47:0]                   m_tdata,
	output int                            outstanding,
	output int                            fail_count,
	output int                            results_checked
);

	localparam int     DEPTH          = fvpc_pkg::SINE_DEPTH_DEF;
	localparam longint HALF_PI_Q30    = 64'd1686629713;
	localparam longint SQRT3_HALF_Q16 = 56756;
	localparam longint DUTY_HALF      = 32768;
	localparam longint DUTY_FULL      = 65536;
	localparam longint DUTY2_FULL     = 131072;

	logic [15:0]   sine_rom [0:DEPTH];
	longint        period_now = longint'(fvpc_pkg::PERIOD_RESET);
	logic [47:0]   due_compares [$];
	logic [47:0]   want;
	int            bad = 0;
	int            seen = 0;
	string         phase_name [3] = '{"a", "b", "c"};

	initial outstanding = 0;
	initial fail_count = 0;
	initial results_checked = 0;

	// Quarter-wave table from a truncated Taylor series in Q30, rounded to Q1.15.
	function automatic void fill_sine_rom();
		longint unsigned x, term, v;
		longint sum;
		for (int k = 0; k <= DEPTH; k++) begin
			x = HALF_PI_Q30 * longint'(k) / DEPTH;
			term = x;
			sum = x;
			for (int n = 1; n <= 6; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / ((2 * n) * (2 * n + 1));
				if (n % 2)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
			if (v > 32767)
				v = 32767;
			sine_rom[k] = v[15:0];
		end
	endfunction

	initial fill_sine_rom();

	function automatic longint quarter_sine(input longint p);
		longint prod, idx, frac, lo_v, hi_v;
		prod = p * DEPTH;
		idx = prod >> 14;
		frac = prod & 16383;
		if (idx > DEPTH)
			idx = DEPTH;
		lo_v = longint'(sine_rom[idx]);
		if (idx < DEPTH)
			hi_v = longint'(sine_rom[idx + 1]);
		else
			hi_v = lo_v;
		return lo_v + (((hi_v - lo_v) * frac) >>> 14);
	endfunction

	// Bit 14 selects a mirrored quadrant, bit 15 a negative half wave.
	function automatic longint sine16(input logic [15:0] a);
		longint m;
		if (a[14])
			m = quarter_sine(16384 - longint'(a[13:0]));
		else
			m = quarter_sine(longint'(a[13:0]));
		return a[15] ? -m : m;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Inverse Park, inverse Clarke, offsets, duty, midpoint clamp and period scaling.
	function automatic logic [47:0] predict_compares(input logic [111:0] cmd);
		longint vq, vd, vs, sa, ca, ualpha, ubeta, lo, hi, shift, mag, quo, dd;
		longint u [3];
		longint duty2 [3];
		logic [15:0] ang;
		logic [47:0] res;
		vq = longint'($signed(cmd[15:0]));
		vd = longint'($signed(cmd[31:16]));
		ang = cmd[47:32];
		vs = longint'(cmd[110:96]);
		// A supply of zero is taken as one LSB.
		if (vs == 0)
			vs = 1;
		sa = sine16(ang);
		ca = sine16(ang + 16'd16384);
		ualpha = ca * vd - sa * vq;
		ubeta = sa * vd + ca * vq;
		u[0] = ualpha;
		u[1] = (-32768 * ualpha + SQRT3_HALF_Q16 * ubeta + 32768) >>> 16;
		u[2] = (-32768 * ualpha - SQRT3_HALF_Q16 * ubeta + 32768) >>> 16;
		for (int j = 0; j < 3; j++) begin
			u[j] = u[j] - longint'($signed(cmd[48 + 16 * j +: 16])) * 32768;
			mag = (u[j] < 0) ? -u[j] : u[j];
			quo = (2 * mag + vs) / (2 * vs);
			if (u[j] < 0)
				quo = -quo;
			duty2[j] = 2 * clip(quo + DUTY_HALF, 0, DUTY_FULL);
		end
		lo = duty2[0];
		hi = duty2[0];
		for (int j = 1; j < 3; j++) begin
			if (duty2[j] < lo)
				lo = duty2[j];
			if (duty2[j] > hi)
				hi = duty2[j];
		end
		shift = DUTY_FULL - (hi + lo);
		for (int j = 0; j < 3; j++) begin
			dd = clip(duty2[j] + shift, 0, DUTY2_FULL);
			res[16 * j +: 16] = 16'((dd * period_now + DUTY_FULL) >>> 17);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_now = longint'(fvpc_pkg::PERIOD_RESET);
		end else begin
			if (cfg_we)
				period_now = longint'(cfg_wdata);
			if (s_tvalid && s_tready)
				due_compares.push_back(predict_compares(s_tdata));
			if (m_tvalid && m_tready) begin
				seen++;
				if (due_compares.size() == 0) begin
					if (bad < 10)
						$display("Unexpected result transaction %h with nothing outstanding",
							m_tdata);
					bad++;
				end else begin
					want = due_compares.pop_front();
					for (int j = 0; j < 3; j++) begin
						if (m_tdata[16 * j +: 16] !== want[16 * j +: 16]) begin
							if (bad < 10)
								$display("Result %0d compare_%s: expected %0d, got %0d",
									seen, phase_name[j], want[16 * j +: 16],
									m_tdata[16 * j +: 16]);
							bad++;
						end
					end
				end
			end
			outstanding <= due_compares.size();
			fail_count <= bad;
			results_checked <= seen;
		end
	end

endmodule

@@ verif/foc_voltage_to_pwm_compare_tb.sv @@
// Testbench top for foc_voltage_to_pwm_compare: clock, reset, stimulus and verdict.
// Needs the RTL with fvpc_pkg and the checker module fvpc_compare_checker.
module foc_voltage_to_pwm_compare_tb;

	localparam int IN_W        = ((6 * fvpc_pkg::VOLT_BITS_DEF + 15 + 7) / 8) * 8;
	localparam int OUT_W       = 3 * fvpc_pkg::COMPARE_W;
	localparam int PIPE_DEPTH  = fvpc_pkg::PIPE_LAT;
	// Longest receiver hold-off; long enough to fill every stage of the pipeline.
	localparam int HOLD_CYCLES = 300;
	// Cycles without any transaction before the run is declared stuck.
	localparam int STUCK_LIMIT = 4000;
	localparam int PHASE_ITEMS = 205;
	localparam int N_PHASES    = 7;

	typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_e;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [fvpc_pkg::PERIOD_W-1:0] cfg_wdata = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [IN_W-1:0]               s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [OUT_W-1:0]              m_tdata;

	int outstanding;
	int fail_count;
	int results_checked;

	// Sender state: commands left in the present burst, and whether gaps are suppressed.
	int burst_left = 0;
	bit gapless = 1'b0;
	int commands_sent = 0;

	// Receiver state. A hold-off is requested by bumping hold_asks.
	int       hold_asks = 0;
	int       hold_seen = 0;
	int       hold_left = 0;
	rx_mode_e rx_mode = RX_ALWAYS;
	int       rx_left = 0;
	int       stuck = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	foc_voltage_to_pwm_compare uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	fvpc_compare_checker compare_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.outstanding     (outstanding),
		.fail_count      (fail_count),
		.results_checked (results_checked)
	);

	// The receiver switches between several stall patterns, each held for a random
	// stretch. A requested hold-off overrides the pattern and keeps m_tready low until a
	// counter loaded from HOLD_CYCLES has run down; it is counted here rather than by the sender.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_e'($urandom_range(0, 3));
				rx_left <= $urandom_range(20, 200);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_HALF:   m_tready <= ($urandom_range(0, 1) == 0);
				RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
				default:   m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Watchdog: a run in which neither side completes a transaction before the idle
	// counter reaches STUCK_LIMIT has hung.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck <= 0;
		end else if (stuck >= STUCK_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", STUCK_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	// Packs one command, first field in the lowest bits and the spare top bit zero.
	function automatic logic [IN_W-1:0] pack_cmd(input int vq, input int vd, input int ang,
			input int oa, input int ob, input int oc, input int vs);
		return {1'b0, 15'(vs), 16'(oc), 16'(ob), 16'(oa), 16'(ang), 16'(vd), 16'(vq)};
	endfunction

	// Most commands are plausible for the chosen supply, so that duties land inside the
	// clamp window and the midpoint shift does real work; the rest are raw noise that
	// saturates freely. A few use a tiny supply.
	function automatic logic [IN_W-1:0] random_cmd();
		logic [127:0] raw;
		int vs, amp, off_amp;
		if ($urandom_range(0, 9) < 3) begin
			raw = {$urandom, $urandom, $urandom, $urandom};
			raw[IN_W-1] = 1'b0;
			return raw[IN_W-1:0];
		end
		if ($urandom_range(0, 9) == 0)
			vs = $urandom_range(0, 16);
		else
			vs = $urandom_range(64, 32767);
		amp = ($urandom_range(0, 1) == 0) ? vs / 2 : vs;
		if (amp == 0)
			amp = 1;
		off_amp = vs / 16;
		return pack_cmd(int'($urandom_range(0, 2 * amp)) - amp,
			int'($urandom_range(0, 2 * amp)) - amp,
			$urandom_range(0, 65535),
			int'($urandom_range(0, 2 * off_amp)) - off_amp,
			int'($urandom_range(0, 2 * off_amp)) - off_amp,
			int'($urandom_range(0, 2 * off_amp)) - off_amp,
			vs);
	endfunction

	// Offers one command until it is taken. Bursts end with a random gap unless gaps are
	// suppressed; tvalid is only lowered when a gap really follows.
	task automatic send_cmd(input logic [IN_W-1:0] cmd);
		int gap;
		s_tdata <= cmd;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		commands_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0 && !gapless) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Stops offering and waits until every expected result has arrived.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_period(input logic [fvpc_pkg::PERIOD_W-1:0] period);
		cfg_wdata <= period;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [fvpc_pkg::PERIOD_W-1:0] periods [N_PHASES];
		periods[0] = 16'd65535;
		periods[1] = 16'd1;
		periods[2] = 16'd0;
		periods[3] = 16'($urandom_range(2, 65534));
		periods[4] = 16'($urandom_range(2, 999));
		periods[5] = 16'd20000;
		periods[6] = fvpc_pkg::PERIOD_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner cases at the reset period: saturation with the smallest supply, the
		// quadrant boundaries including the very end of the sine table, offset extremes
		// and a supply of zero.
		send_cmd(pack_cmd(0, 0, 0, 0, 0, 0, 32767));
		send_cmd(pack_cmd(32767, 0, 0, 0, 0, 0, 1));
		send_cmd(pack_cmd(-32768, -32768, 16384, 0, 0, 0, 1));
		send_cmd(pack_cmd(32767, 32767, 32768, 0, 0, 0, 32767));
		send_cmd(pack_cmd(-32768, 32767, 49152, 0, 0, 0, 32767));
		send_cmd(pack_cmd(256, 0, 65535, 0, 0, 0, 1024));
		send_cmd(pack_cmd(0, 256, 8192, 0, 0, 0, 1024));
		send_cmd(pack_cmd(0, 0, 0, 32767, -32768, 0, 256));
		send_cmd(pack_cmd(0, 0, 0, -32768, 32767, 32767, 256));
		send_cmd(pack_cmd(512, 512, 12345, 0, 0, 0, 0));
		send_cmd(pack_cmd(0, 0, 0, 0, 0, 0, 0));
		send_cmd(pack_cmd(100, -50, 16383, 10, -10, 5, 3000));
		send_cmd(pack_cmd(3000, 0, 24576, 0, 0, 0, 6000));
		send_cmd(pack_cmd(-1, -1, 1, -1, -1, -1, 1));
		send_cmd(pack_cmd(1, 1, 32767, 1, 1, 1, 2));
		send_cmd(pack_cmd(0, 4096, 40960, 0, 0, 0, 8192));
		send_cmd(pack_cmd(32767, -32768, 57344, -32768, -32768, -32768, 32767));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			// The period may only change with the pipeline empty.
			drain();
			write_period(periods[ph]);
			if (ph == 0) begin
				// Keep offering back to back while the receiver holds off, so the
				// pipeline fills and s_tready has to fall.
				gapless = 1'b1;
				hold_asks <= hold_asks + 1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 0 && i == 120)
					gapless = 1'b0;
				send_cmd(random_cmd());
			end
		end

		drain();
		repeat (PIPE_DEPTH + 4) @(posedge clk);

		$display("Sent %0d command transactions and checked %0d result transactions",
			commands_sent, results_checked);
		$display("over %0d PWM periods including 0, 1 and 65535, with zero and tiny supplies.",
			N_PHASES + 1);
		if (fail_count == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", fail_count, outstanding);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
